@@ rtl/gsa_pkg.sv @@
// Package: field widths, command and status codes, parameter defaults for the slot allocator.
`default_nettype none
package gsa_pkg;
   localparam int INDEX_BITS          = 10;
   localparam int GEN_PORT_BITS       = 16;
   localparam int CMD_BITS            = 2;
   localparam int STATUS_BITS         = 2;
   localparam int SLOT_COUNT_DEF      = 1024;
   localparam int GENERATION_BITS_DEF = 16;

   typedef logic [CMD_BITS-1:0]    cmd_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam cmd_type CMD_SPAWN  = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_CHECK  = 2'd2;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_FULL    = 2'd1;
   localparam status_type STATUS_INVALID = 2'd2;
endpackage
`default_nettype wire

@@ rtl/gsa_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module gsa_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 17
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ rtl/generational_slot_allocator.sv @@
// Top level: generational slot allocator with slot table RAM and free stack RAM.
//
//   channel   ports                                        handshake
//   request   req_command, req_handle_index,               start & !busy
//             req_handle_generation
//   response  rsp_slot_index, rsp_slot_generation,         rsp_strobe, one cycle
//             rsp_status
//
// Each request: the accept edge reads the slot table and the free stack top, and the
// next edge writes the RAMs that the command needs and registers the response.
// busy is high for the one cycle in between; a new request may start in the cycle
// the response is shown. The response cannot be stalled.
// Reset clears the state, strobe and counters only; slots at or above the issued count
// are never live and spawn with generation zero, so no clearing pass is needed.
`default_nettype none
module generational_slot_allocator
   import gsa_pkg::*;
#(
   parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
   parameter int GENERATION_BITS = GENERATION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [CMD_BITS-1:0]      req_command,
   input  wire logic [INDEX_BITS-1:0]    req_handle_index,
   input  wire logic [GEN_PORT_BITS-1:0] req_handle_generation,
   output      logic                     rsp_strobe,
   output      logic [INDEX_BITS-1:0]    rsp_slot_index,
   output      logic [GEN_PORT_BITS-1:0] rsp_slot_generation,
   output      logic [STATUS_BITS-1:0]   rsp_status
);
   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int GB      = GENERATION_BITS;
   localparam int CMP_W   = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;
   localparam int GCMP_W  = (GB > GEN_PORT_BITS) ? GB : GEN_PORT_BITS;
   localparam int SLOT_W  = GB + 1;
   localparam int STACK_W = IDX_W + GB;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         free_count_ff, free_count_in;
   logic [CNT_W-1:0]         issued_count_ff, issued_count_in;
   cmd_type                  cmd_ff;
   logic [INDEX_BITS-1:0]    idx_ff;
   logic [GEN_PORT_BITS-1:0] gen_ff;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [GEN_PORT_BITS-1:0] rsp_gen_ff, rsp_gen_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic [CMP_W-1:0]         req_idx_ext;
   logic [CMP_W-1:0]         idx_ext;
   logic [CNT_W-1:0]         stack_top;
   logic [SLOT_W-1:0]        slot_rd;
   logic [STACK_W-1:0]       stack_rd;
   logic [GB-1:0]            slot_gen;
   logic [GB-1:0]            next_gen;
   logic                     handle_ok;
   logic                     slot_we;
   logic [IDX_W-1:0]         slot_waddr;
   logic [SLOT_W-1:0]        slot_wdata;
   logic                     stack_we;
   logic [IDX_W-1:0]         pick_idx;
   logic [GB-1:0]            pick_gen;

   assign busy        = state_ff;
   assign accept      = start & ~busy;
   assign req_idx_ext = CMP_W'(req_handle_index);
   assign idx_ext     = CMP_W'(idx_ff);
   assign stack_top   = free_count_ff - CNT_W'(1);
   assign slot_gen    = slot_rd[SLOT_W-1:1];
   assign next_gen    = slot_gen + GB'(1);
   assign handle_ok   = (idx_ext < CMP_W'(issued_count_ff))
                        && (GCMP_W'(slot_gen) == GCMP_W'(gen_ff))
                        && slot_rd[0];

   gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (accept),
      .rd_addr (req_idx_ext[IDX_W-1:0]),
      .rd_data (slot_rd)
   );

   // free stack entries carry the slot's generation so a pop needs no second read
   gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(STACK_W)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (free_count_ff[IDX_W-1:0]),
      .wr_data ({idx_ext[IDX_W-1:0], next_gen}),
      .rd_en   (accept),
      .rd_addr (stack_top[IDX_W-1:0]),
      .rd_data (stack_rd)
   );

   always_comb begin
      state_in        = state_ff;
      free_count_in   = free_count_ff;
      issued_count_in = issued_count_ff;
      rsp_strobe_in   = 1'b0;
      rsp_index_in    = idx_ff;
      rsp_gen_in      = gen_ff;
      rsp_status_in   = STATUS_INVALID;
      slot_we         = 1'b0;
      slot_waddr      = idx_ext[IDX_W-1:0];
      slot_wdata      = {next_gen, 1'b0};
      stack_we        = 1'b0;
      pick_idx        = issued_count_ff[IDX_W-1:0];
      pick_gen        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            case (cmd_ff)
               CMD_SPAWN: begin
                  if (free_count_ff != '0) begin
                     pick_idx      = stack_rd[STACK_W-1:GB];
                     pick_gen      = stack_rd[GB-1:0];
                     free_count_in = stack_top;
                  end else if (issued_count_ff != CNT_W'(SLOT_COUNT)) begin
                     issued_count_in = issued_count_ff + CNT_W'(1);
                  end
                  if ((free_count_ff != '0) || (issued_count_ff != CNT_W'(SLOT_COUNT))) begin
                     slot_we       = 1'b1;
                     slot_waddr    = pick_idx;
                     slot_wdata    = {pick_gen, 1'b1};
                     rsp_index_in  = INDEX_BITS'(pick_idx);
                     rsp_gen_in    = GEN_PORT_BITS'(pick_gen);
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               CMD_DELETE: begin
                  if (handle_ok) begin
                     slot_we       = 1'b1;
                     rsp_status_in = STATUS_OK;
                     if (free_count_ff != CNT_W'(SLOT_COUNT)) begin
                        stack_we      = 1'b1;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end
               end
               CMD_CHECK: begin
                  rsp_status_in = handle_ok ? STATUS_OK : STATUS_INVALID;
               end
               default: begin
                  rsp_status_in = STATUS_INVALID;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         free_count_ff   <= '0;
         issued_count_ff <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         free_count_ff   <= free_count_in;
         issued_count_ff <= issued_count_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         idx_ff <= req_handle_index;
         gen_ff <= req_handle_generation;
      end
      if (rsp_strobe_in) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_gen_ff    <= rsp_gen_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_slot_index      = rsp_index_ff;
   assign rsp_slot_generation = rsp_gen_ff;
   assign rsp_status          = rsp_status_ff;
endmodule
`default_nettype wire

@@ rtl/gsa_checker.sv @@
// Port-level checker for the slot allocator, bound to the top level.
`default_nettype none
module gsa_checker
   import gsa_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic [CMD_BITS-1:0]      req_command,
   input wire logic [INDEX_BITS-1:0]    req_handle_index,
   input wire logic [GEN_PORT_BITS-1:0] req_handle_generation,
   input wire logic                     rsp_strobe,
   input wire logic [INDEX_BITS-1:0]    rsp_slot_index,
   input wire logic [GEN_PORT_BITS-1:0] rsp_slot_generation,
   input wire logic [STATUS_BITS-1:0]   rsp_status
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("busy cycle not followed by a response");

   a_resp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in flight");

   a_full_spawn: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_FULL)) |-> ($past(req_command, 2) == CMD_SPAWN))
      else $error("full status on a command other than spawn");

   a_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_command, 2) != CMD_SPAWN))
      |-> ((rsp_slot_index == $past(req_handle_index, 2))
           && (rsp_slot_generation == $past(req_handle_generation, 2))))
      else $error("handle not echoed on delete or check");
endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
`default_nettype wire
